// ===== src/suv_pkg.sv =====
// Shared constants, codes and types of the song upload validator.
package suv_pkg;

    localparam int SLOT_COUNT = 8;
    localparam int MAX_EVENTS = 65536;

    localparam int CNT_W  = $clog2(MAX_EVENTS + 1);
    localparam int CNT_EXT_W = CNT_W + 1;
    localparam int TIME_W = 27;
    localparam int OUT_CNT_W = 17;
    localparam int MOTOR_COUNT = 6;

    localparam logic [31:0] TIME_LIMIT_MS = 32'd86400000;
    localparam logic [31:0] NOTE_MIN      = 32'd20000;
    localparam logic [31:0] NOTE_MAX      = 32'd4000000;
    localparam logic [7:0]  END_MOTOR     = 8'd255;
    localparam logic [7:0]  MASK_MAX      = 8'd63;
    localparam logic [7:0]  RAW_MODE_MAX  = 8'd7;
    localparam logic [7:0]  DIR_MAX       = 8'd63;

    localparam logic [1:0] CMD_BEGIN  = 2'd0;
    localparam logic [1:0] CMD_EVENT  = 2'd1;
    localparam logic [1:0] CMD_COMMIT = 2'd2;

    localparam logic [7:0] OP_SILENCE = 8'd0;
    localparam logic [7:0] OP_NOTE    = 8'd1;
    localparam logic [7:0] OP_END     = 8'd2;

    typedef enum logic [2:0] {
        ERR_OK        = 3'd0,
        ERR_BAD_BEGIN = 3'd1,
        ERR_BAD_EVENT = 3'd2,
        ERR_SEQUENCE  = 3'd3,
        ERR_UNKNOWN   = 3'd4
    } err_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  slot;
        logic [31:0] event_total;
        logic [7:0]  motor_mask;
        logic [7:0]  raw_mode;
        logic [7:0]  direction_bits;
        logic [31:0] time_ms;
        logic [7:0]  motor;
        logic [7:0]  opcode;
        logic [31:0] event_value;
    } item_t;

    typedef struct packed {
        logic                      open_flag;
        logic [CNT_W-1:0]          expected_events;
        logic [CNT_W-1:0]          accepted_events;
        logic [TIME_W-1:0]         last_time;
        logic                      end_flag;
        logic [MOTOR_COUNT-1:0]    enabled_motors;
    } state_t;

    typedef struct packed {
        logic [2:0]            error_code;
        logic                  open_after;
        logic [OUT_CNT_W-1:0]  events_accepted;
        logic                  end_seen;
        logic                  committed;
    } result_t;

endpackage

// ===== src/suv_in_if.sv =====
// Input channel of the song upload validator.
interface suv_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [7:0]  slot;
    logic [31:0] event_total;
    logic [7:0]  motor_mask;
    logic [7:0]  raw_mode;
    logic [7:0]  direction_bits;
    logic [31:0] time_ms;
    logic [7:0]  motor;
    logic [7:0]  opcode;
    logic [31:0] event_value;

    modport source (
        output valid, command, slot, event_total, motor_mask, raw_mode,
               direction_bits, time_ms, motor, opcode, event_value,
        input  ready
    );
    modport sink (
        input  valid, command, slot, event_total, motor_mask, raw_mode,
               direction_bits, time_ms, motor, opcode, event_value,
        output ready
    );
endinterface

// ===== src/suv_out_if.sv =====
// Result channel of the song upload validator.
interface suv_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  error_code;
    logic        open_after;
    logic [16:0] events_accepted;
    logic        end_seen;
    logic        committed;

    modport source (
        output valid, error_code, open_after, events_accepted, end_seen, committed,
        input  ready
    );
    modport sink (
        input  valid, error_code, open_after, events_accepted, end_seen, committed,
        output ready
    );
endinterface

// ===== src/song_upload_validator.sv =====
// Top level of the song upload validator: input register, checks, result register.
//
// Accepts one item per clock cycle sustained while the result side does not stall, and
// returns exactly one result per item; the result is written from the checks on the
// input register into the result register. An item is
// captured in the input register; in the next cycle the checks run against the
// upload state, and the state and the result register are written together, so
// consecutive items see each other's updates with no gap. A stall on the result
// side holds the result register; the input register still takes one more item.
module song_upload_validator (
    input  logic clk,
    input  logic rst_n,
    suv_in_if.sink    req,
    suv_out_if.source rsp
);

    logic             in_valid_reg;
    suv_pkg::item_t   item_reg;
    logic             out_valid_reg;
    suv_pkg::result_t result_reg;
    suv_pkg::state_t  state_reg;
    suv_pkg::state_t  state_next;
    suv_pkg::result_t result_next;
    logic             advance;
    logic             take;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign take      = req.valid && req.ready;

    suv_checker u_checker (
        .item       (item_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.command        <= req.command;
            item_reg.slot           <= req.slot;
            item_reg.event_total    <= req.event_total;
            item_reg.motor_mask     <= req.motor_mask;
            item_reg.raw_mode       <= req.raw_mode;
            item_reg.direction_bits <= req.direction_bits;
            item_reg.time_ms        <= req.time_ms;
            item_reg.motor          <= req.motor;
            item_reg.opcode         <= req.opcode;
            item_reg.event_value    <= req.event_value;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.error_code      = result_reg.error_code;
    assign rsp.open_after      = result_reg.open_after;
    assign rsp.events_accepted = result_reg.events_accepted;
    assign rsp.end_seen        = result_reg.end_seen;
    assign rsp.committed       = result_reg.committed;

endmodule

// ===== src/suv_checker.sv =====
// Per-item checks and next upload state of the song upload validator.
module suv_checker (
    input  suv_pkg::item_t   item,
    input  suv_pkg::state_t  state,
    output suv_pkg::state_t  state_next,
    output suv_pkg::result_t result
);

    logic         begin_ok;
    logic         content_ok;
    logic         room_left;
    logic         motor_enabled;
    logic [31:0]  last_time_ext;
    logic [suv_pkg::CNT_EXT_W-1:0] acc_plus_one;
    suv_pkg::err_t err;
    logic         commit_ok;

    assign last_time_ext = 32'(state.last_time);
    assign acc_plus_one  = suv_pkg::CNT_EXT_W'(state.accepted_events)
                         + suv_pkg::CNT_EXT_W'(1);
    assign room_left     = state.accepted_events < state.expected_events;
    assign motor_enabled = state.enabled_motors[item.motor[2:0]];

    assign begin_ok = (item.slot < 8'(suv_pkg::SLOT_COUNT))
                   && (item.event_total != 32'd0)
                   && (item.event_total <= 32'(suv_pkg::MAX_EVENTS))
                   && (item.motor_mask != 8'd0)
                   && (item.motor_mask <= suv_pkg::MASK_MAX)
                   && (item.raw_mode <= suv_pkg::RAW_MODE_MAX)
                   && (item.direction_bits <= suv_pkg::DIR_MAX);

    always_comb
    begin
        content_ok = 1'b0;
        if (state.end_flag || (item.time_ms < last_time_ext)
            || (item.time_ms > suv_pkg::TIME_LIMIT_MS))
        begin
            content_ok = 1'b0;
        end
        else if (item.opcode == suv_pkg::OP_END)
        begin
            content_ok = (item.motor == suv_pkg::END_MOTOR) && (item.event_value == 32'd0)
                      && (acc_plus_one == suv_pkg::CNT_EXT_W'(state.expected_events));
        end
        else if ((item.opcode == suv_pkg::OP_SILENCE) || (item.opcode == suv_pkg::OP_NOTE))
        begin
            if ((item.motor < 8'(suv_pkg::MOTOR_COUNT)) && motor_enabled)
            begin
                if (item.opcode == suv_pkg::OP_SILENCE)
                begin
                    content_ok = item.event_value == 32'd0;
                end
                else
                begin
                    content_ok = (item.event_value >= suv_pkg::NOTE_MIN)
                              && (item.event_value <= suv_pkg::NOTE_MAX);
                end
            end
        end
    end

    always_comb
    begin
        state_next = state;
        err        = suv_pkg::ERR_OK;
        commit_ok  = 1'b0;
        case (item.command)
            suv_pkg::CMD_BEGIN:
            begin
                state_next.accepted_events = '0;
                state_next.end_flag        = 1'b0;
                state_next.last_time       = '0;
                if (begin_ok)
                begin
                    state_next.expected_events = item.event_total[suv_pkg::CNT_W-1:0];
                    state_next.enabled_motors  = item.motor_mask[suv_pkg::MOTOR_COUNT-1:0];
                    state_next.open_flag       = 1'b1;
                end
                else
                begin
                    err = suv_pkg::ERR_BAD_BEGIN;
                end
            end
            suv_pkg::CMD_EVENT:
            begin
                if (!state.open_flag || !room_left)
                begin
                    err = suv_pkg::ERR_SEQUENCE;
                end
                else if (!content_ok)
                begin
                    err = suv_pkg::ERR_BAD_EVENT;
                end
                else
                begin
                    state_next.last_time       = item.time_ms[suv_pkg::TIME_W-1:0];
                    state_next.end_flag        = item.opcode == suv_pkg::OP_END;
                    state_next.accepted_events = acc_plus_one[suv_pkg::CNT_W-1:0];
                end
            end
            suv_pkg::CMD_COMMIT:
            begin
                if (!state.open_flag || (state.accepted_events != state.expected_events)
                    || !state.end_flag)
                begin
                    err = suv_pkg::ERR_SEQUENCE;
                end
                else
                begin
                    commit_ok = 1'b1;
                end
                state_next.open_flag = 1'b0;
            end
            default:
            begin
                err = suv_pkg::ERR_UNKNOWN;
            end
        endcase
        if (err != suv_pkg::ERR_OK)
        begin
            state_next.open_flag = 1'b0;
        end
    end

    assign result.error_code      = err;
    assign result.open_after      = state_next.open_flag;
    assign result.events_accepted = suv_pkg::OUT_CNT_W'(state_next.accepted_events);
    assign result.end_seen        = state_next.end_flag;
    assign result.committed       = commit_ok;

endmodule
